@@ src/s16cpu_pkg.sv @@
// ----------------------------------------------------------------------------
// s16cpu_pkg
// Shared types, codes and constants of the sixteen-bit register CPU core.
// ----------------------------------------------------------------------------
`default_nettype none

package s16cpu_pkg;

   localparam int WORD_WIDTH      = 16;
   localparam int REG_IDX_WIDTH   = 4;
   localparam int REG_COUNT       = 16;

   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 4;

   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam logic CSR_IDX_IRQ_VECTOR = 1'b0;

   localparam logic [REG_IDX_WIDTH-1:0] REG_R1 = 4'd1;
   localparam logic [REG_IDX_WIDTH-1:0] REG_R2 = 4'd2;
   localparam logic [REG_IDX_WIDTH-1:0] REG_SP = 4'd3;
   localparam logic [REG_IDX_WIDTH-1:0] REG_R9 = 4'd9;
   localparam logic [REG_IDX_WIDTH-1:0] REG_PC = 4'd15;

   localparam logic [WORD_WIDTH-1:0] RESET_R1 = 16'h0001;
   localparam logic [WORD_WIDTH-1:0] RESET_R2 = 16'hAEB0;
   localparam logic [WORD_WIDTH-1:0] RESET_SP = 16'hAE70;
   localparam logic [WORD_WIDTH-1:0] RESET_R9 = 16'h0050;
   localparam logic [WORD_WIDTH-1:0] RESET_PC = 16'h0000;

   typedef enum logic [1:0] {
      OPER_RESUME = 2'd0,
      OPER_INSTR  = 2'd1,
      OPER_DATA   = 2'd2,
      OPER_TICK   = 2'd3
   } operation_type;

   typedef enum logic [3:0] {
      OPC_LOAD  = 4'd0,
      OPC_ADD   = 4'd1,
      OPC_SUB   = 4'd2,
      OPC_AND   = 4'd3,
      OPC_OR    = 4'd4,
      OPC_XOR   = 4'd5,
      OPC_SHIFT = 4'd6,
      OPC_MUL   = 4'd7,
      OPC_STORE = 4'd8,
      OPC_CMOV  = 4'd9,
      OPC_GTU   = 4'd10,
      OPC_GTS   = 4'd11,
      OPC_LTU   = 4'd12,
      OPC_LTS   = 4'd13,
      OPC_EQU   = 4'd14,
      OPC_JAL   = 4'd15
   } opcode_type;

   typedef enum logic [1:0] {
      ACC_FETCH = 2'd0,
      ACC_READ  = 2'd1,
      ACC_WRITE = 2'd2
   } access_type;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_FETCH = 2'd1,
      PHASE_LOAD  = 2'd2
   } phase_type;

   typedef struct packed {
      operation_type                   kind;
      opcode_type                      opc;
      logic [REG_IDX_WIDTH-1:0]        dest;
      logic [REG_IDX_WIDTH-1:0]        src1;
      logic [REG_IDX_WIDTH-1:0]        src2;
      logic [WORD_WIDTH-1:0]           word;
   } cmd_type;

   typedef struct packed {
      access_type                      access;
      logic [WORD_WIDTH-1:0]           address;
      logic [WORD_WIDTH-1:0]           write_data;
      logic                            last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                      count;
      rsp_type                         beat0;
      rsp_type                         beat1;
   } rsp_push_type;

   function automatic logic [WORD_WIDTH-1:0] reg_reset_value(
      input logic [REG_IDX_WIDTH-1:0] idx
   );
      logic [WORD_WIDTH-1:0] value;
      case (idx)
         REG_R1:  value = RESET_R1;
         REG_R2:  value = RESET_R2;
         REG_SP:  value = RESET_SP;
         REG_R9:  value = RESET_R9;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

@@ src/s16cpu_front.sv @@
// ----------------------------------------------------------------------------
// s16cpu_front
// Request intake: classifies each beat and decodes instruction fields into a
// short command queue toward the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module s16cpu_front
   import s16cpu_pkg::*;
#(
   parameter int Depth = CMD_QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_operation,
   input  wire logic [WORD_WIDTH-1:0] req_word,
   output logic                       cmd_valid,
   output cmd_type                    cmd,
   input  wire logic                  cmd_pop
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCount = CntWidth'(Depth);

   cmd_type               slot_ff [Depth];
   cmd_type               incoming;
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  push;

   always_comb begin
      incoming.kind = operation_type'(req_operation);
      incoming.opc  = opcode_type'(req_word[15:12]);
      incoming.dest = req_word[11:8];
      incoming.src1 = req_word[7:4];
      incoming.src2 = req_word[3:0];
      incoming.word = req_word;
   end

   assign req_ready = (count_ff != FullCount);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, cmd_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

`default_nettype wire

@@ src/s16cpu_back.sv @@
// ----------------------------------------------------------------------------
// s16cpu_back
// Execution side: operand register stage with register file, ALU, wait-phase
// sequencer, interrupt entry and memory request generation.
// ----------------------------------------------------------------------------
`default_nettype none

module s16cpu_back
   import s16cpu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [WORD_WIDTH-1:0] irq_vector,
   input  wire logic                  cmd_valid,
   input  wire cmd_type               cmd,
   output logic                       cmd_pop,
   input  wire logic                  rsp_room,
   output rsp_push_type               rsp_push
);

   typedef enum logic [1:0] {
      SHIFT_ASR = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_LSL = 2'd2,
      SHIFT_ROL = 2'd3
   } shift_mode_type;

   logic [WORD_WIDTH-1:0]     regfile_mem [REG_COUNT];
   logic [REG_COUNT-1:0]      valid_ff;

   logic                      ex_valid_ff, ex_valid_in;
   cmd_type                   ex_ff;
   logic [WORD_WIDTH-1:0]     a_mem_ff, b_mem_ff;
   logic [WORD_WIDTH-1:0]     pc_ff, pc_in;
   logic [WORD_WIDTH-1:0]     sp_ff, sp_in;
   phase_type                 phase_ff, phase_in;
   logic                      pending_ff, pending_in;
   logic [REG_IDX_WIDTH-1:0]  load_dest_ff, load_dest_in;
   logic                      load_pc_ff, load_pc_in;

   logic                      fire;
   logic [WORD_WIDTH-1:0]     a, b, b_upd, alu_val;
   logic [WORD_WIDTH-1:0]     shift_val;
   logic [2*WORD_WIDTH-1:0]   rot_val;
   logic [3:0]                shamt;
   shift_mode_type            shift_mode;

   logic                      wr_en;
   logic [REG_IDX_WIDTH-1:0]  wr_idx;
   logic [WORD_WIDTH-1:0]     wr_val;
   logic                      mem_we;
   logic                      do_bd, allow_irq, take_tick, irq;
   logic                      is_store, is_jump, data_inc, issue_read;
   logic [WORD_WIDTH-1:0]     pc_wr, pc_mid, sp_mid, sp_dec, fetch_addr;
   rsp_type                   fetch_beat, write_beat;

   assign fire        = ex_valid_ff && rsp_room;
   assign cmd_pop     = cmd_valid && (!ex_valid_ff || fire);
   assign ex_valid_in = cmd_pop ? 1'b1 : (fire ? 1'b0 : ex_valid_ff);

   // Operand select: PC and SP live outside the register file.
   always_comb begin
      if (ex_ff.src1 == REG_PC) begin
         a = pc_ff;
      end else if (ex_ff.src1 == REG_SP) begin
         a = sp_ff;
      end else begin
         a = a_mem_ff;
      end
      if (ex_ff.src2 == REG_PC) begin
         b = pc_ff;
      end else if (ex_ff.src2 == REG_SP) begin
         b = sp_ff;
      end else begin
         b = b_mem_ff;
      end
      b_upd = (ex_ff.src2 == ex_ff.dest) ? a : b;
   end

   always_comb begin
      shamt      = b[3:0];
      shift_mode = shift_mode_type'(b[5:4]);
      rot_val    = {a, a} << shamt;
      case (shift_mode)
         SHIFT_ASR: shift_val = WORD_WIDTH'($signed(a) >>> shamt);
         SHIFT_LSR: shift_val = a >> shamt;
         SHIFT_LSL: shift_val = a << shamt;
         SHIFT_ROL: shift_val = rot_val[2*WORD_WIDTH-1:WORD_WIDTH];
         default:   shift_val = a;
      endcase
   end

   always_comb begin
      case (ex_ff.opc)
         OPC_ADD:   alu_val = a + b;
         OPC_SUB:   alu_val = a - b;
         OPC_AND:   alu_val = a & b;
         OPC_OR:    alu_val = a | b;
         OPC_XOR:   alu_val = a ^ b;
         OPC_SHIFT: alu_val = shift_val;
         OPC_MUL:   alu_val = a * b;
         OPC_GTU:   alu_val = WORD_WIDTH'(a > b);
         OPC_GTS:   alu_val = WORD_WIDTH'($signed(a) > $signed(b));
         OPC_LTU:   alu_val = WORD_WIDTH'(a < b);
         OPC_LTS:   alu_val = WORD_WIDTH'($signed(a) < $signed(b));
         OPC_EQU:   alu_val = WORD_WIDTH'(a == b);
         default:   alu_val = '0;
      endcase
   end

   // Phase sequencer and request generation.
   always_comb begin
      wr_en        = 1'b0;
      wr_idx       = ex_ff.dest;
      wr_val       = alu_val;
      do_bd        = 1'b0;
      allow_irq    = 1'b1;
      is_store     = 1'b0;
      is_jump      = 1'b0;
      data_inc     = 1'b0;
      issue_read   = 1'b0;
      pending_in   = pending_ff;
      phase_in     = phase_ff;
      load_dest_in = load_dest_ff;
      load_pc_in   = load_pc_ff;

      case (ex_ff.kind)
         OPER_TICK: begin
            pending_in = 1'b1;
         end
         OPER_RESUME: begin
            do_bd = (phase_ff == PHASE_IDLE);
         end
         OPER_INSTR: begin
            if (phase_ff == PHASE_FETCH) begin
               case (ex_ff.opc)
                  OPC_LOAD: begin
                     issue_read   = 1'b1;
                     phase_in     = PHASE_LOAD;
                     load_dest_in = ex_ff.dest;
                     load_pc_in   = (ex_ff.src2 == REG_PC) && (ex_ff.dest != REG_PC);
                  end
                  OPC_STORE: begin
                     wr_en     = 1'b1;
                     wr_val    = a;
                     is_store  = 1'b1;
                     allow_irq = 1'b0;
                     do_bd     = 1'b1;
                  end
                  OPC_CMOV: begin
                     wr_en  = (a != '0);
                     wr_val = b;
                     do_bd  = 1'b1;
                  end
                  OPC_JAL: begin
                     wr_en   = 1'b1;
                     wr_val  = a;
                     is_jump = 1'b1;
                     do_bd   = 1'b1;
                  end
                  default: begin
                     wr_en = 1'b1;
                     do_bd = 1'b1;
                  end
               endcase
            end
         end
         OPER_DATA: begin
            if (phase_ff == PHASE_LOAD) begin
               wr_en    = 1'b1;
               wr_idx   = load_dest_ff;
               wr_val   = ex_ff.word;
               data_inc = load_pc_ff;
               do_bd    = 1'b1;
            end
         end
         default: begin
            do_bd = 1'b0;
         end
      endcase

      pc_wr  = (wr_en && wr_idx == REG_PC) ? wr_val : pc_ff;
      sp_mid = (wr_en && wr_idx == REG_SP) ? wr_val : sp_ff;
      mem_we = fire && wr_en && (wr_idx != REG_PC) && (wr_idx != REG_SP);

      pc_mid = pc_wr;
      if ((is_store && ex_ff.src2 == REG_PC) || data_inc) begin
         pc_mid = pc_wr + 1'b1;
      end
      if (is_jump) begin
         pc_mid = b_upd;
      end

      take_tick = do_bd && allow_irq && pending_ff;
      irq       = take_tick && (irq_vector != '0);
      if (take_tick) begin
         pending_in = 1'b0;
      end
      sp_dec     = sp_mid - 1'b1;
      fetch_addr = irq ? irq_vector : pc_mid;
      pc_in      = do_bd ? fetch_addr + 1'b1 : pc_ff;
      sp_in      = irq ? sp_dec : sp_mid;
      if (do_bd) begin
         phase_in = PHASE_FETCH;
      end

      fetch_beat.access     = ACC_FETCH;
      fetch_beat.address    = fetch_addr;
      fetch_beat.write_data = '0;
      fetch_beat.last       = 1'b1;

      write_beat.access     = ACC_WRITE;
      write_beat.address    = is_store ? b_upd : sp_dec;
      write_beat.write_data = is_store ? a : pc_mid;
      write_beat.last       = 1'b0;

      rsp_push.count = 2'd0;
      rsp_push.beat0 = fetch_beat;
      rsp_push.beat1 = fetch_beat;
      if (issue_read) begin
         rsp_push.count            = 2'd1;
         rsp_push.beat0.access     = ACC_READ;
         rsp_push.beat0.address    = b;
         rsp_push.beat0.write_data = '0;
         rsp_push.beat0.last       = 1'b1;
      end else if (do_bd) begin
         if (is_store || irq) begin
            rsp_push.count = 2'd2;
            rsp_push.beat0 = write_beat;
         end else begin
            rsp_push.count = 2'd1;
         end
      end
      if (!fire) begin
         rsp_push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         pc_ff        <= RESET_PC;
         sp_ff        <= RESET_SP;
         phase_ff     <= PHASE_IDLE;
         pending_ff   <= 1'b0;
         load_dest_ff <= '0;
         load_pc_ff   <= 1'b0;
         valid_ff     <= '0;
      end else begin
         ex_valid_ff <= ex_valid_in;
         if (fire) begin
            pc_ff        <= pc_in;
            sp_ff        <= sp_in;
            phase_ff     <= phase_in;
            pending_ff   <= pending_in;
            load_dest_ff <= load_dest_in;
            load_pc_ff   <= load_pc_in;
         end
         if (mem_we) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // Register file: one write, two registered reads with write bypass.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         regfile_mem[wr_idx] <= wr_val;
      end
      if (cmd_pop) begin
         ex_ff <= cmd;
         if (mem_we && wr_idx == cmd.src1) begin
            a_mem_ff <= wr_val;
         end else if (valid_ff[cmd.src1]) begin
            a_mem_ff <= regfile_mem[cmd.src1];
         end else begin
            a_mem_ff <= reg_reset_value(cmd.src1);
         end
         if (mem_we && wr_idx == cmd.src2) begin
            b_mem_ff <= wr_val;
         end else if (valid_ff[cmd.src2]) begin
            b_mem_ff <= regfile_mem[cmd.src2];
         end else begin
            b_mem_ff <= reg_reset_value(cmd.src2);
         end
      end
   end

endmodule

`default_nettype wire

@@ src/s16cpu_rsp_queue.sv @@
// ----------------------------------------------------------------------------
// s16cpu_rsp_queue
// Request output queue: takes up to two beats per cycle from the execution
// side while it reports room, and drains one beat per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module s16cpu_rsp_queue
   import s16cpu_pkg::*;
#(
   parameter int Depth = RSP_QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire rsp_push_type push,
   output logic              room,
   output logic              head_valid,
   input  wire logic         head_ready,
   output rsp_type           head
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] RoomLimit = CntWidth'(Depth - 2);

   rsp_type               slot_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic [PtrWidth-1:0]   wr_ptr_next;
   logic                  pop;

   function automatic logic [PtrWidth-1:0] next_ptr(input logic [PtrWidth-1:0] p);
      return (p == LastPtr) ? '0 : p + 1'b1;
   endfunction

   assign room        = (count_ff <= RoomLimit);
   assign head_valid  = (count_ff != '0);
   assign head        = slot_ff[rd_ptr_ff];
   assign pop         = head_valid && head_ready;
   assign wr_ptr_next = next_ptr(wr_ptr_ff);

   always_comb begin
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_next;
         2'd2:    wr_ptr_in = next_ptr(wr_ptr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntWidth'(push.count) - CntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.beat0;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ptr_next] <= push.beat1;
      end
   end

endmodule

`default_nettype wire

@@ src/sixteen_bit_register_cpu_core.sv @@
// ----------------------------------------------------------------------------
// sixteen_bit_register_cpu_core
// Path: an item passes the command queue, the register-file read stage and the
// response queue before its first request beat is presented.
// Throughput: one item per cycle while the response queue has room; each item drives
// zero to two request beats; the output moves one beat per cycle while rsp_ready is high.
// Reset: synchronous; queues empty, core idle, registers at their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module sixteen_bit_register_cpu_core
   import s16cpu_pkg::*;
#(
   parameter int CmdQueueDepth = CMD_QUEUE_DEPTH,
   parameter int RspQueueDepth = RSP_QUEUE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_operation,
   input  wire logic [WORD_WIDTH-1:0]     req_word,

   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [1:0]                     rsp_access,
   output logic [WORD_WIDTH-1:0]          rsp_address,
   output logic [WORD_WIDTH-1:0]          rsp_write_data,
   output logic                           rsp_last,

   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]      csr_prdata,
   output logic                           csr_pready
);

   logic [WORD_WIDTH-1:0] irq_vector_ff, irq_vector_in;
   logic                  csr_write;
   logic                  cmd_valid;
   logic                  cmd_pop;
   cmd_type               cmd;
   logic                  rsp_room;
   rsp_push_type          rsp_push;
   rsp_type               rsp_head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_IDX_IRQ_VECTOR);
   assign irq_vector_in = csr_write ? csr_pwdata[WORD_WIDTH-1:0] : irq_vector_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_IRQ_VECTOR) ?
                       CSR_DATA_WIDTH'(irq_vector_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_vector_ff <= '0;
      end else begin
         irq_vector_ff <= irq_vector_in;
      end
   end

   s16cpu_front #(
      .Depth (CmdQueueDepth)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_word      (req_word),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   s16cpu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .irq_vector (irq_vector_ff),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_room   (rsp_room),
      .rsp_push   (rsp_push)
   );

   s16cpu_rsp_queue #(
      .Depth (RspQueueDepth)
   ) u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (rsp_push),
      .room       (rsp_room),
      .head_valid (rsp_valid),
      .head_ready (rsp_ready),
      .head       (rsp_head)
   );

   assign rsp_access     = rsp_head.access;
   assign rsp_address    = rsp_head.address;
   assign rsp_write_data = rsp_head.write_data;
   assign rsp_last       = rsp_head.last;

`ifndef ASSERT_OFF
   read_is_last_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_access == ACC_READ) |-> rsp_last)
      else $error("data read beat not marked last");

   only_write_leads_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (rsp_access == ACC_WRITE))
      else $error("non-final beat is not a write");

   push_needs_room_a: assert property (@(posedge clock) disable iff (reset)
      (rsp_push.count != 2'd0) |-> rsp_room)
      else $error("beats pushed without queue room");

   push_shows_beat_a: assert property (@(posedge clock) disable iff (reset)
      (rsp_push.count != 2'd0) |=> rsp_valid)
      else $error("pushed beat not presented");
`endif

endmodule

`default_nettype wire

@@ test/sixteen_bit_register_cpu_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sixteen_bit_register_cpu_core_test
// Drives resume, instruction, load-data and tick beats into the core and checks
// every memory request beat: typed directed rows against their table beat, the
// rest against a cycle-free model of the core kept in this bench. A directed
// table runs first, then several interrupt-vector settings with random, mostly
// well-formed traffic under varying stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------

module sixteen_bit_register_cpu_core_test;
   import s16cpu_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 12;
   localparam int PHASE_ITEMS    = 300;
   localparam int N_DIRECTED     = 26;
   localparam rsp_type NO_BEAT   = '0;

   typedef struct {
      operation_type op;
      logic [15:0]   word;
      bit            typed;
      bit            one_beat;
      rsp_type       beat;
   } directed_row_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_operation = OPER_RESUME;
   logic [WORD_WIDTH-1:0]     req_word = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_access;
   logic [WORD_WIDTH-1:0]     rsp_address;
   logic [WORD_WIDTH-1:0]     rsp_write_data;
   logic                      rsp_last;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   // model state
   logic [15:0] arch_regs [16];
   phase_type   cpu_phase;
   logic        tick_seen;
   logic [3:0]  load_target;
   logic        load_from_pc;
   logic [15:0] irq_vector_q;

   rsp_type new_requests[$];
   rsp_type expected_requests[$];

   int  mismatch_count = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  holdoff_left = 0;
   bit  holdoff_req = 1'b0;
   bit  holdoff_taken = 1'b0;
   int  quiet_cycles = 0;

   directed_row_type directed_rows [N_DIRECTED] = '{
      '{OPER_INSTR,  16'hFFFF, 1'b1, 1'b0, NO_BEAT},
      '{OPER_RESUME, 16'h0000, 1'b1, 1'b1, '{ACC_FETCH, 16'h0000, 16'h0000, 1'b1}},
      '{OPER_RESUME, 16'h0000, 1'b1, 1'b0, NO_BEAT},
      '{OPER_DATA,   16'hFFFF, 1'b1, 1'b0, NO_BEAT},
      '{OPER_INSTR,  16'h1419, 1'b1, 1'b1, '{ACC_FETCH, 16'h0001, 16'h0000, 1'b1}},
      '{OPER_INSTR,  16'h050F, 1'b1, 1'b1, '{ACC_READ,  16'h0002, 16'h0000, 1'b1}},
      '{OPER_INSTR,  16'h0000, 1'b1, 1'b0, NO_BEAT},
      '{OPER_DATA,   16'hFFFF, 1'b1, 1'b1, '{ACC_FETCH, 16'h0003, 16'h0000, 1'b1}},
      '{OPER_INSTR,  16'h2601, 1'b0, 1'b0, NO_BEAT},
      '{OPER_INSTR,  16'h3756, 1'b0, 1'b0, NO_BEAT},
      '{OPER_INSTR,  16'h4829, 1'b0, 1'b0, NO_BEAT},
      '{OPER_INSTR,  16'h5A23, 1'b0, 1'b0, NO_BEAT},
      '{OPER_INSTR,  16'h6B54, 1'b0, 1'b0, NO_BEAT},
      '{OPER_INSTR,  16'h6C51, 1'b0, 1'b0, NO_BEAT},
      '{OPER_INSTR,  16'h7E55, 1'b0, 1'b0, NO_BEAT},
      '{OPER_TICK,   16'h0000, 1'b1, 1'b0, NO_BEAT},
      '{OPER_INSTR,  16'h8E5F, 1'b0, 1'b0, NO_BEAT},
      '{OPER_INSTR,  16'h9051, 1'b0, 1'b0, NO_BEAT},
      '{OPER_INSTR,  16'hA056, 1'b0, 1'b0, NO_BEAT},
      '{OPER_INSTR,  16'hB056, 1'b0, 1'b0, NO_BEAT},
      '{OPER_INSTR,  16'hC023, 1'b0, 1'b0, NO_BEAT},
      '{OPER_INSTR,  16'hD023, 1'b0, 1'b0, NO_BEAT},
      '{OPER_INSTR,  16'hE055, 1'b0, 1'b0, NO_BEAT},
      '{OPER_INSTR,  16'hF014, 1'b0, 1'b0, NO_BEAT},
      '{OPER_INSTR,  16'h0F0F, 1'b0, 1'b0, NO_BEAT},
      '{OPER_DATA,   16'h8000, 1'b0, 1'b0, NO_BEAT}
   };

   sixteen_bit_register_cpu_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_access     (rsp_access),
      .rsp_address    (rsp_address),
      .rsp_write_data (rsp_write_data),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic void add_request(input access_type acc, input logic [15:0] addr,
                                       input logic [15:0] data);
      rsp_type r;
      r.access     = acc;
      r.address    = addr;
      r.write_data = data;
      r.last       = 1'b0;
      new_requests.push_back(r);
   endfunction

   function automatic void take_boundary(input bit allow_irq);
      if (allow_irq && tick_seen) begin
         tick_seen = 1'b0;
         if (irq_vector_q != 16'h0000) begin
            arch_regs[REG_SP] = arch_regs[REG_SP] - 16'd1;
            add_request(ACC_WRITE, arch_regs[REG_SP], arch_regs[REG_PC]);
            arch_regs[REG_PC] = irq_vector_q;
         end
      end
      add_request(ACC_FETCH, arch_regs[REG_PC], 16'h0000);
      arch_regs[REG_PC] = arch_regs[REG_PC] + 16'd1;
      cpu_phase = PHASE_FETCH;
   endfunction

   function automatic void execute_word(input logic [15:0] ir);
      opcode_type        opc;
      logic [3:0]        d;
      logic [3:0]        s1;
      logic [3:0]        s2;
      logic [15:0]       a;
      logic [15:0]       b;
      logic signed [15:0] sa;
      logic signed [15:0] sb;
      logic [3:0]        n;
      logic [31:0]       rot;
      opc = opcode_type'(ir[15:12]);
      d   = ir[11:8];
      s1  = ir[7:4];
      s2  = ir[3:0];
      a   = arch_regs[s1];
      b   = arch_regs[s2];
      sa  = a;
      sb  = b;
      case (opc)
         OPC_LOAD: begin
            load_target  = d;
            load_from_pc = (s2 == REG_PC) && (d != REG_PC);
            cpu_phase    = PHASE_LOAD;
            add_request(ACC_READ, b, 16'h0000);
            return;
         end
         OPC_ADD: arch_regs[d] = a + b;
         OPC_SUB: arch_regs[d] = a - b;
         OPC_AND: arch_regs[d] = a & b;
         OPC_OR:  arch_regs[d] = a | b;
         OPC_XOR: arch_regs[d] = a ^ b;
         OPC_SHIFT: begin
            n = b[3:0];
            case (b[5:4])
               2'd0: arch_regs[d] = sa >>> n;
               2'd1: arch_regs[d] = a >> n;
               2'd2: arch_regs[d] = a << n;
               default: begin
                  rot = {a, a} << n;
                  arch_regs[d] = rot[31:16];
               end
            endcase
         end
         OPC_MUL: arch_regs[d] = a * b;
         OPC_STORE: begin
            arch_regs[d] = a;
            add_request(ACC_WRITE, arch_regs[s2], a);
            if (s2 == REG_PC) arch_regs[REG_PC] = arch_regs[REG_PC] + 16'd1;
            // a tick stays pending across the store
            take_boundary(1'b0);
            return;
         end
         OPC_CMOV: if (a != 16'h0000) arch_regs[d] = b;
         OPC_GTU: arch_regs[d] = (a > b) ? 16'd1 : 16'd0;
         OPC_GTS: arch_regs[d] = (sa > sb) ? 16'd1 : 16'd0;
         OPC_LTU: arch_regs[d] = (a < b) ? 16'd1 : 16'd0;
         OPC_LTS: arch_regs[d] = (sa < sb) ? 16'd1 : 16'd0;
         OPC_EQU: arch_regs[d] = (a == b) ? 16'd1 : 16'd0;
         default: begin
            arch_regs[d] = a;
            arch_regs[REG_PC] = arch_regs[s2];
         end
      endcase
      take_boundary(1'b1);
   endfunction

   // returns 0 when the core drops the beat
   function automatic bit predict_requests(input operation_type op, input logic [15:0] w);
      rsp_type tail;
      new_requests.delete();
      case (op)
         OPER_TICK: begin
            tick_seen = 1'b1;
            return 1'b1;
         end
         OPER_RESUME: begin
            if (cpu_phase != PHASE_IDLE) return 1'b0;
            take_boundary(1'b1);
         end
         OPER_INSTR: begin
            if (cpu_phase != PHASE_FETCH) return 1'b0;
            execute_word(w);
         end
         default: begin
            if (cpu_phase != PHASE_LOAD) return 1'b0;
            arch_regs[load_target] = w;
            if (load_from_pc) arch_regs[REG_PC] = arch_regs[REG_PC] + 16'd1;
            take_boundary(1'b1);
         end
      endcase
      tail = new_requests.pop_back();
      tail.last = 1'b1;
      new_requests.push_back(tail);
      return 1'b1;
   endfunction

   task automatic send_item(input operation_type op, input logic [15:0] w, input bit typed,
                            input bit one_beat, input rsp_type beat, output bit active);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_word      <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      active = predict_requests(op, w);
      if (typed) begin
         if (one_beat) expected_requests.push_back(beat);
      end else begin
         foreach (new_requests[i]) expected_requests.push_back(new_requests[i]);
      end
   endtask

   task automatic program_irq_vector(input logic [15:0] value);
      req_valid <= 1'b0;
      while (expected_requests.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_IDX_IRQ_VECTOR, 2'b00};
      csr_pwdata  <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      irq_vector_q = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {16'h0000, value})
         report_mismatch($sformatf("irq_vector read %h, wrote %h", csr_prdata, value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_random(input int target);
      int            done_items;
      int            pick;
      operation_type op;
      logic [15:0]   w;
      bit            active;
      done_items = 0;
      while (done_items < target) begin
         pick = $urandom_range(99);
         w    = 16'($urandom);
         if (pick < 6) begin
            op = operation_type'($urandom_range(3));
         end else if (pick < 11) begin
            op = OPER_TICK;
         end else begin
            case (cpu_phase)
               PHASE_IDLE:  op = OPER_RESUME;
               PHASE_FETCH: op = OPER_INSTR;
               default:     op = OPER_DATA;
            endcase
         end
         send_item(op, w, 1'b0, 1'b0, NO_BEAT, active);
         if (active) done_items++;
      end
   endtask

   always @(posedge clock) begin
      if (holdoff_req && !holdoff_taken) begin
         holdoff_taken <= 1'b1;
         holdoff_left  <= HOLDOFF_CYCLES;
         rsp_ready     <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_requests.size() == 0) begin
            report_mismatch($sformatf("unexpected beat access=%0d addr=%h data=%h last=%b",
                                      rsp_access, rsp_address, rsp_write_data, rsp_last));
         end else begin
            want = expected_requests.pop_front();
            if (rsp_access !== want.access)
               report_mismatch($sformatf("access %0d, want %0d", rsp_access, want.access));
            if (rsp_address !== want.address)
               report_mismatch($sformatf("address %h, want %h", rsp_address, want.address));
            if (rsp_write_data !== want.write_data)
               report_mismatch($sformatf("write_data %h, want %h",
                                         rsp_write_data, want.write_data));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %b, want %b", rsp_last, want.last));
         end
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [15:0] vector_plan [6];
      bit          active;
      foreach (arch_regs[i]) arch_regs[i] = 16'h0000;
      arch_regs[REG_R1] = RESET_R1;
      arch_regs[REG_R2] = RESET_R2;
      arch_regs[REG_SP] = RESET_SP;
      arch_regs[REG_R9] = RESET_R9;
      arch_regs[REG_PC] = RESET_PC;
      cpu_phase    = PHASE_IDLE;
      tick_seen    = 1'b0;
      load_target  = 4'd0;
      load_from_pc = 1'b0;
      irq_vector_q = 16'h0000;
      vector_plan  = '{16'hFFFF, 16'h0004, 16'($urandom_range(16'hFFFF, 1)),
                       16'h0001, 16'h0000, 16'($urandom_range(16'hFFFF, 1))};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      program_irq_vector(16'h0000);

      send_idle_pct = 13;
      recv_idle_pct = 50;
      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].word, directed_rows[i].typed,
                   directed_rows[i].one_beat, directed_rows[i].beat, active);

      for (int p = 0; p < 6; p++) begin
         program_irq_vector(vector_plan[p]);
         send_idle_pct = (p < 2) ? 13 : (p < 4) ? 50 : 0;
         recv_idle_pct = (p < 2) ? 50 : (p < 4) ? 13 : 0;
         if (p == 4) holdoff_req <= 1'b1;
         run_random(PHASE_ITEMS);
      end

      req_valid <= 1'b0;
      while (expected_requests.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ files.f @@
src/s16cpu_pkg.sv
src/s16cpu_front.sv
src/s16cpu_back.sv
src/s16cpu_rsp_queue.sv
src/sixteen_bit_register_cpu_core.sv
test/sixteen_bit_register_cpu_core_test.sv
